// File: sv/cmbd_pkg.sv
// ----------------------------------------------------------------------------
// Console memory bus decoder package
// Shared types, memory map constants and helpers for the bus decoder.
// ----------------------------------------------------------------------------
package cmbd_pkg;

    // Default build parameters.
    localparam int          DEF_VIDEO_BANKS      = 2;
    localparam int          DEF_WORK_BANKS       = 8;
    localparam logic [15:0] DEF_SERIAL_DATA_ADDR = 16'hFF01;
    localparam logic [15:0] DEF_SERIAL_CTRL_ADDR = 16'hFF02;
    localparam logic [15:0] DEF_DIVIDER_ADDR     = 16'hFF04;
    localparam logic [15:0] DEF_BOOT_OFF_ADDR    = 16'hFF50;

    // Bank geometry.
    localparam int VBANK_SIZE = 8192;
    localparam int WBANK_SIZE = 4096;
    localparam int VBANK_W    = 13;
    localparam int WBANK_W    = 12;

    // Fixed store sizes.
    localparam int SPRITE_DEPTH = 160;
    localparam int IO_DEPTH     = 128;
    localparam int HRAM_DEPTH   = 127;
    localparam int BOOT_DEPTH   = 256;
    localparam int IO_AW        = 7;

    // Memory map boundaries.
    localparam logic [15:0] ADDR_BOOT_END = 16'h0100;
    localparam logic [15:0] ADDR_VRAM     = 16'h8000;
    localparam logic [15:0] ADDR_XRAM     = 16'hA000;
    localparam logic [15:0] ADDR_WRAM0    = 16'hC000;
    localparam logic [15:0] ADDR_WRAMX    = 16'hD000;
    localparam logic [15:0] ADDR_ECHO     = 16'hE000;
    localparam logic [15:0] ADDR_OAM      = 16'hFE00;
    localparam logic [15:0] ADDR_RSVD     = 16'hFEA0;
    localparam logic [15:0] ADDR_IO       = 16'hFF00;
    localparam logic [15:0] ADDR_HRAM     = 16'hFF80;
    localparam logic [15:0] ADDR_IE       = 16'hFFFF;

    localparam logic [7:0] SERIAL_GO   = 8'h81;
    localparam logic [7:0] SERIAL_MASK = 8'h7F;
    localparam logic [7:0] OPEN_BUS    = 8'hFF;

    // Bus function codes.
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_LOAD  = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_INDEX_W      = 2;
    localparam int         CFG_DATA_W       = 3;
    localparam logic [1:0] CFG_VIDEO_BANK   = 2'd0;
    localparam logic [1:0] CFG_WORK_BANK    = 2'd1;
    localparam logic [1:0] CFG_CART_PRESENT = 2'd2;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_LOAD,
        OP_NONE
    } t_op;

    typedef enum logic [3:0] {
        RG_NONE,
        RG_OPEN,
        RG_CART,
        RG_BOOT,
        RG_VRAM,
        RG_WRAM,
        RG_OAM,
        RG_IO,
        RG_HRAM,
        RG_IE
    } t_region;

    // Decoded bus access handed from the decoder to the datapath.
    typedef struct packed {
        t_op     op;
        t_region region;
        logic    wram_banked;
    } t_access;

    // Bank number modulo a small bank count, by repeated subtraction.
    function automatic logic [2:0] bank_wrap(input logic [2:0] bank, input int count);
        logic [3:0] v;
        v = {1'b0, bank};
        for (int i = 0; i < 8; i++) begin
            if (v >= 4'(count)) begin
                v = v - 4'(count);
            end
        end
        return v[2:0];
    endfunction

endpackage

// File: sv/cmbd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle: write, or read with registered read data.
// ----------------------------------------------------------------------------
module cmbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/cmbd_decode.sv
// ----------------------------------------------------------------------------
// Bus address decoder
// Maps one bus function and address onto the region that serves it.
// ----------------------------------------------------------------------------
module cmbd_decode (
    input  logic              [1:0]  i_func,
    input  logic              [15:0] i_address,
    input  logic                     i_cart_present,
    input  logic                     i_boot_on,
    output cmbd_pkg::t_access        o_access
);
    import cmbd_pkg::*;

    t_op     op;
    t_region region;
    logic    banked;
    t_region cart_or_open;

    assign cart_or_open = i_cart_present ? RG_CART : RG_OPEN;

    always_comb begin
        case (i_func)
            FUNC_READ:  op = OP_READ;
            FUNC_WRITE: op = OP_WRITE;
            FUNC_LOAD:  op = OP_LOAD;
            default:    op = OP_NONE;
        endcase
    end

    always_comb begin
        banked = 1'b0;
        if (op == OP_LOAD) begin
            region = RG_BOOT;
        end else if (op == OP_NONE) begin
            region = RG_NONE;
        end else if (i_address == ADDR_IE) begin
            region = RG_IE;
        end else if (i_address < ADDR_VRAM) begin
            // The boot ROM shadows the bottom page for reads only.
            if (op == OP_READ && i_address < ADDR_BOOT_END && i_boot_on) begin
                region = RG_BOOT;
            end else begin
                region = cart_or_open;
            end
        end else if (i_address < ADDR_XRAM) begin
            region = RG_VRAM;
        end else if (i_address < ADDR_WRAM0) begin
            region = cart_or_open;
        end else if (i_address < ADDR_ECHO) begin
            region = RG_WRAM;
            banked = (i_address >= ADDR_WRAMX);
        end else if (i_address < ADDR_OAM) begin
            region = RG_OPEN;
        end else if (i_address < ADDR_RSVD) begin
            region = RG_OAM;
        end else if (i_address < ADDR_IO) begin
            region = RG_OPEN;
        end else if (i_address < ADDR_HRAM) begin
            region = RG_IO;
        end else begin
            region = RG_HRAM;
        end
    end

    assign o_access = '{op: op, region: region, wram_banked: banked};

endmodule

// File: sv/console_memory_bus_decoder.sv
// ----------------------------------------------------------------------------
// Console memory bus decoder
// Serves CPU bus reads, writes and boot ROM loads from the on-chip stores.
// ----------------------------------------------------------------------------
// Each input beat carries one bus access (read, write or boot ROM load) plus
// the byte the cartridge drives for that address. Each access produces exactly
// one output beat: the read byte, cartridge select and write strobe, and the
// serial byte when a write to serial control starts a transfer.
// The stores are single-port RAMs accessed on the edge that accepts the beat;
// the read stage holds the beat until the output advances, then the result
// register loads it and the result beat can be taken. One beat per cycle is
// sustained while the receiver takes every result, bounded by the single port
// of each RAM: every access uses one port once.
// When the receiver stalls, up to two beats are held inside (the RAM read
// stage and the result register) and the input ready drops once both are full.
// Reset clears the I/O bytes, the interrupt-enable register and the bank and
// cartridge configuration. Video RAM, work RAM, the sprite table, high RAM and
// the boot ROM keep whatever they hold and must be written before being read;
// there is no clearing pass. Configuration writes take effect at once; the user
// must make them only while no beat is in flight: the block does not enforce it.
// ----------------------------------------------------------------------------
module console_memory_bus_decoder #(
    parameter int          VIDEO_BANKS      = cmbd_pkg::DEF_VIDEO_BANKS,
    parameter int          WORK_BANKS       = cmbd_pkg::DEF_WORK_BANKS,
    parameter logic [15:0] SERIAL_DATA_ADDR = cmbd_pkg::DEF_SERIAL_DATA_ADDR,
    parameter logic [15:0] SERIAL_CTRL_ADDR = cmbd_pkg::DEF_SERIAL_CTRL_ADDR,
    parameter logic [15:0] DIVIDER_ADDR     = cmbd_pkg::DEF_DIVIDER_ADDR,
    parameter logic [15:0] BOOT_OFF_ADDR    = cmbd_pkg::DEF_BOOT_OFF_ADDR
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port
    input  logic                                i_cfg_we,
    input  logic [cmbd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [cmbd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Bus access channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_func,
    input  logic [15:0]                         i_address,
    input  logic [7:0]                          i_write_data,
    input  logic [7:0]                          i_cart_read_data,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_read_data,
    output logic                                o_cart_select,
    output logic                                o_cart_write_strobe,
    output logic                                o_serial_valid,
    output logic [7:0]                          o_serial_char
);
    import cmbd_pkg::*;

    localparam int VRAM_DEPTH = VIDEO_BANKS * VBANK_SIZE;
    localparam int WRAM_DEPTH = WORK_BANKS * WBANK_SIZE;
    localparam int VA_W       = $clog2(VRAM_DEPTH);
    localparam int WA_W       = $clog2(WRAM_DEPTH);

    // Configuration registers
    logic       r_video_bank;
    logic [2:0] r_work_bank;
    logic       r_cart_present;

    // Architectural state kept in flops
    logic [7:0]          r_irq_enable;
    logic [IO_DEPTH-1:0] r_io_written;
    logic [7:0]          r_serial_data;
    logic                r_boot_on;

    // Read stage
    logic       r_s1_valid;
    t_op        r_s1_op;
    t_region    r_s1_region;
    logic [7:0] r_s1_direct;
    logic       r_s1_io_written;
    logic       r_s1_serial_valid;
    logic [7:0] r_s1_serial_char;

    // Result register
    logic       r_out_valid;
    logic [7:0] r_out_read_data;
    logic       r_out_cart_select;
    logic       r_out_cart_write;
    logic       r_out_serial_valid;
    logic [7:0] r_out_serial_char;

    t_access acc;
    logic    accept;
    logic    advance;
    logic    is_write;
    logic    io_write;
    logic    serial_fire;
    logic [7:0] io_store;
    logic [7:0] n_s1_direct;
    logic [7:0] n_serial_char;
    logic [7:0] s1_read_byte;
    logic [7:0] n_out_read_data;

    logic [2:0]  vbank;
    logic [2:0]  wbank;
    logic [15:0] vram_full;
    logic [14:0] wram_full;
    logic [VA_W-1:0] vram_addr;
    logic [WA_W-1:0] wram_addr;

    logic [7:0] vram_rdata;
    logic [7:0] wram_rdata;
    logic [7:0] oam_rdata;
    logic [7:0] io_rdata;
    logic [7:0] hram_rdata;
    logic [7:0] boot_rdata;

    cmbd_decode u_decode (
        .i_func         (i_func),
        .i_address      (i_address),
        .i_cart_present (r_cart_present),
        .i_boot_on      (r_boot_on),
        .o_access       (acc)
    );

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || advance;
    assign accept     = i_in_valid && o_in_ready;
    assign is_write   = (acc.op == OP_WRITE);
    assign io_write   = accept && is_write && (acc.region == RG_IO);

    // Bank selection and RAM addresses
    assign vbank     = bank_wrap({2'b00, r_video_bank}, VIDEO_BANKS);
    assign wbank     = acc.wram_banked ? bank_wrap(r_work_bank, WORK_BANKS) : 3'd0;
    assign vram_full = {vbank, i_address[VBANK_W-1:0]};
    assign wram_full = {wbank, i_address[WBANK_W-1:0]};
    assign vram_addr = vram_full[VA_W-1:0];
    assign wram_addr = wram_full[WA_W-1:0];

    // Byte stored on an I/O write, with serial start and divider side effects.
    assign serial_fire = is_write && (acc.region == RG_IO) &&
                         (i_address == SERIAL_CTRL_ADDR) && (i_write_data == SERIAL_GO);

    always_comb begin
        io_store = i_write_data;
        if (i_address == SERIAL_CTRL_ADDR) begin
            if (i_write_data == SERIAL_GO) begin
                io_store = i_write_data & SERIAL_MASK;
            end
        end else if (i_address == DIVIDER_ADDR) begin
            io_store = 8'h00;
        end
    end

    // When the data and control registers share an address, the byte just
    // written is the one sent.
    assign n_serial_char = !serial_fire ? 8'h00 :
                           (SERIAL_DATA_ADDR == SERIAL_CTRL_ADDR) ? i_write_data :
                           r_serial_data;

    always_comb begin
        case (acc.region)
            RG_IE:   n_s1_direct = r_irq_enable;
            RG_CART: n_s1_direct = i_cart_read_data;
            RG_OPEN: n_s1_direct = OPEN_BUS;
            default: n_s1_direct = 8'h00;
        endcase
    end

    cmbd_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
        .i_clk   (i_clk),
        .i_en    (accept && acc.region == RG_VRAM),
        .i_we    (is_write),
        .i_addr  (vram_addr),
        .i_wdata (i_write_data),
        .o_rdata (vram_rdata)
    );

    cmbd_ram #(.WIDTH(8), .DEPTH(WRAM_DEPTH)) u_wram (
        .i_clk   (i_clk),
        .i_en    (accept && acc.region == RG_WRAM),
        .i_we    (is_write),
        .i_addr  (wram_addr),
        .i_wdata (i_write_data),
        .o_rdata (wram_rdata)
    );

    cmbd_ram #(.WIDTH(8), .DEPTH(SPRITE_DEPTH)) u_oam (
        .i_clk   (i_clk),
        .i_en    (accept && acc.region == RG_OAM),
        .i_we    (is_write),
        .i_addr  (i_address[7:0]),
        .i_wdata (i_write_data),
        .o_rdata (oam_rdata)
    );

    cmbd_ram #(.WIDTH(8), .DEPTH(IO_DEPTH)) u_io (
        .i_clk   (i_clk),
        .i_en    (accept && acc.region == RG_IO),
        .i_we    (is_write),
        .i_addr  (i_address[IO_AW-1:0]),
        .i_wdata (io_store),
        .o_rdata (io_rdata)
    );

    cmbd_ram #(.WIDTH(8), .DEPTH(HRAM_DEPTH)) u_hram (
        .i_clk   (i_clk),
        .i_en    (accept && acc.region == RG_HRAM),
        .i_we    (is_write),
        .i_addr  (i_address[IO_AW-1:0]),
        .i_wdata (i_write_data),
        .o_rdata (hram_rdata)
    );

    cmbd_ram #(.WIDTH(8), .DEPTH(BOOT_DEPTH)) u_boot (
        .i_clk   (i_clk),
        .i_en    (accept && acc.region == RG_BOOT),
        .i_we    (acc.op == OP_LOAD),
        .i_addr  (i_address[7:0]),
        .i_wdata (i_write_data),
        .o_rdata (boot_rdata)
    );

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_bank   <= 1'b0;
            r_work_bank    <= 3'd0;
            r_cart_present <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VIDEO_BANK:   r_video_bank   <= i_cfg_data[0];
                CFG_WORK_BANK:    r_work_bank    <= i_cfg_data[2:0];
                CFG_CART_PRESENT: r_cart_present <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Interrupt enable, I/O written bits and the I/O bytes the decoder watches.
    // An I/O byte never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_enable  <= 8'h00;
            r_io_written  <= '0;
            r_serial_data <= 8'h00;
            r_boot_on     <= 1'b1;
        end else begin
            if (accept && is_write && acc.region == RG_IE) begin
                r_irq_enable <= i_write_data;
            end
            if (io_write) begin
                r_io_written[i_address[IO_AW-1:0]] <= 1'b1;
                if (i_address == SERIAL_DATA_ADDR) begin
                    r_serial_data <= io_store;
                end
                if (i_address == BOOT_OFF_ADDR) begin
                    r_boot_on <= (io_store == 8'h00);
                end
            end
        end
    end

    // Read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op           <= acc.op;
            r_s1_region       <= acc.region;
            r_s1_direct       <= n_s1_direct;
            r_s1_io_written   <= r_io_written[i_address[IO_AW-1:0]];
            r_s1_serial_valid <= serial_fire;
            r_s1_serial_char  <= n_serial_char;
        end
    end

    always_comb begin
        case (r_s1_region)
            RG_VRAM: s1_read_byte = vram_rdata;
            RG_WRAM: s1_read_byte = wram_rdata;
            RG_OAM:  s1_read_byte = oam_rdata;
            RG_HRAM: s1_read_byte = hram_rdata;
            RG_BOOT: s1_read_byte = boot_rdata;
            RG_IO:   s1_read_byte = r_s1_io_written ? io_rdata : 8'h00;
            default: s1_read_byte = r_s1_direct;
        endcase
    end

    assign n_out_read_data = (r_s1_op == OP_READ) ? s1_read_byte : 8'h00;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_read_data    <= n_out_read_data;
            r_out_cart_select  <= (r_s1_region == RG_CART) &&
                                  (r_s1_op == OP_READ || r_s1_op == OP_WRITE);
            r_out_cart_write   <= (r_s1_region == RG_CART) && (r_s1_op == OP_WRITE);
            r_out_serial_valid <= r_s1_serial_valid;
            r_out_serial_char  <= r_s1_serial_char;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_out_read_data;
    assign o_cart_select       = r_out_cart_select;
    assign o_cart_write_strobe = r_out_cart_write;
    assign o_serial_valid      = r_out_serial_valid;
    assign o_serial_char       = r_out_serial_char;

    // Assertions
    a_strobe_needs_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cart_write_strobe |-> o_cart_select)
        else $error("cartridge write strobe without cartridge select");

    a_serial_is_local_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_serial_valid |-> !o_cart_select && o_read_data == 8'h00)
        else $error("serial start on a beat that is not a local write");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !advance |-> !o_in_ready)
        else $error("input accepted while the read stage is blocked");

    a_stall_keeps_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !advance |=> r_s1_valid && $stable(r_s1_region))
        else $error("read stage beat lost during a stall");

    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_s1_valid && r_s1_op != OP_READ |=> o_read_data == 8'h00)
        else $error("nonzero read data on a write or load beat");

endmodule

// File: bench/console_memory_bus_decoder_tb.sv
// ----------------------------------------------------------------------------
// Console memory bus decoder testbench
// Drives bus reads, writes and boot ROM loads through the access channel. A
// scoreboard predicts each result beat from its own copy of the stores and
// compares it with what the block returns.
// ----------------------------------------------------------------------------
module console_memory_bus_decoder_tb;
    import cmbd_pkg::*;

    localparam int VRAM_DEPTH     = DEF_VIDEO_BANKS * VBANK_SIZE;
    localparam int WRAM_DEPTH     = DEF_WORK_BANKS * WBANK_SIZE;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 155;
    localparam int TIMEOUT_CYCLES = 200000;

    typedef struct {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  cdata;
    } t_bus_access;

    typedef struct packed {
        logic [7:0] rdata;
        logic       csel;
        logic       cwr;
        logic       sval;
        logic [7:0] schar;
    } t_bus_result;

    class t_bus_scoreboard;
        logic [7:0]  vram [VRAM_DEPTH];
        logic [7:0]  wram [WRAM_DEPTH];
        logic [7:0]  oam [SPRITE_DEPTH];
        logic [7:0]  io [IO_DEPTH];
        logic [7:0]  hram [HRAM_DEPTH];
        logic [7:0]  boot [BOOT_DEPTH];
        bit          vram_set [VRAM_DEPTH];
        bit          wram_set [WRAM_DEPTH];
        bit          oam_set [SPRITE_DEPTH];
        bit          hram_set [HRAM_DEPTH];
        bit          boot_set [BOOT_DEPTH];
        logic [7:0]  ie;
        logic        vbank;
        logic [2:0]  wbank;
        logic        cart_on;
        t_bus_result pending_results [$];
        int          errors;

        function new();
            foreach (io[i]) io[i] = 8'h00;
            ie      = 8'h00;
            vbank   = 1'b0;
            wbank   = 3'd0;
            cart_on = 1'b0;
            errors  = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [2:0] val);
            case (idx)
                CFG_VIDEO_BANK:   vbank = val[0];
                CFG_WORK_BANK:    wbank = val;
                CFG_CART_PRESENT: cart_on = val[0];
                default: begin
                end
            endcase
        endfunction

        function int io_slot(logic [15:0] a);
            return int'(a[IO_AW-1:0]);
        endfunction

        function int vram_index(logic [15:0] a);
            return (int'(vbank) % DEF_VIDEO_BANKS) * VBANK_SIZE
                   + int'(a - ADDR_VRAM) % VBANK_SIZE;
        endfunction

        function int wram_index(logic [2:0] bank, logic [15:0] a);
            return (int'(bank) % DEF_WORK_BANKS) * WBANK_SIZE + int'(a) % WBANK_SIZE;
        endfunction

        function bit boot_window();
            return io[io_slot(DEF_BOOT_OFF_ADDR)] == 8'h00;
        endfunction

        // True when a read of this address touches no store entry that is
        // still unwritten.
        function bit read_defined(logic [15:0] a);
            if (a == ADDR_IE) return 1'b1;
            if (a < ADDR_VRAM) return !(a < ADDR_BOOT_END && boot_window()) || boot_set[a[7:0]];
            if (a < ADDR_XRAM) return vram_set[vram_index(a)];
            if (a >= ADDR_WRAM0 && a < ADDR_WRAMX) return wram_set[wram_index(3'd0, a)];
            if (a >= ADDR_WRAMX && a < ADDR_ECHO) return wram_set[wram_index(wbank, a)];
            if (a >= ADDR_OAM && a < ADDR_RSVD) return oam_set[a - ADDR_OAM];
            if (a >= ADDR_HRAM) return hram_set[a - ADDR_HRAM];
            return 1'b1;
        endfunction

        function void note_access(t_bus_access acc);
            t_bus_result r;
            logic [15:0] a;
            r = '0;
            a = acc.addr;
            case (acc.op)
                OP_READ: begin
                    if (a == ADDR_IE) r.rdata = ie;
                    else if (a < ADDR_VRAM) begin
                        if (a < ADDR_BOOT_END && boot_window()) r.rdata = boot[a[7:0]];
                        else if (cart_on) begin
                            r.rdata = acc.cdata;
                            r.csel  = 1'b1;
                        end else r.rdata = OPEN_BUS;
                    end
                    else if (a < ADDR_XRAM) r.rdata = vram[vram_index(a)];
                    else if (a < ADDR_WRAM0) begin
                        if (cart_on) begin
                            r.rdata = acc.cdata;
                            r.csel  = 1'b1;
                        end else r.rdata = OPEN_BUS;
                    end
                    else if (a < ADDR_WRAMX) r.rdata = wram[wram_index(3'd0, a)];
                    else if (a < ADDR_ECHO) r.rdata = wram[wram_index(wbank, a)];
                    else if (a < ADDR_OAM) r.rdata = OPEN_BUS;
                    else if (a < ADDR_RSVD) r.rdata = oam[a - ADDR_OAM];
                    else if (a < ADDR_IO) r.rdata = OPEN_BUS;
                    else if (a < ADDR_HRAM) r.rdata = io[io_slot(a)];
                    else r.rdata = hram[a - ADDR_HRAM];
                end
                OP_WRITE: begin
                    if (a == ADDR_IE) ie = acc.wdata;
                    else if (a < ADDR_VRAM || (a >= ADDR_XRAM && a < ADDR_WRAM0)) begin
                        if (cart_on) begin
                            r.csel = 1'b1;
                            r.cwr  = 1'b1;
                        end
                    end
                    else if (a < ADDR_XRAM) begin
                        vram[vram_index(a)]     = acc.wdata;
                        vram_set[vram_index(a)] = 1'b1;
                    end
                    else if (a < ADDR_WRAMX) begin
                        wram[wram_index(3'd0, a)]     = acc.wdata;
                        wram_set[wram_index(3'd0, a)] = 1'b1;
                    end
                    else if (a < ADDR_ECHO) begin
                        wram[wram_index(wbank, a)]     = acc.wdata;
                        wram_set[wram_index(wbank, a)] = 1'b1;
                    end
                    else if (a < ADDR_OAM) begin
                        // The echo area drops writes.
                    end
                    else if (a < ADDR_RSVD) begin
                        oam[a - ADDR_OAM]     = acc.wdata;
                        oam_set[a - ADDR_OAM] = 1'b1;
                    end
                    else if (a < ADDR_IO) begin
                        // The restricted area drops writes too.
                    end
                    else if (a < ADDR_HRAM) begin
                        io[io_slot(a)] = acc.wdata;
                        if (a == DEF_SERIAL_CTRL_ADDR && acc.wdata == SERIAL_GO) begin
                            r.sval = 1'b1;
                            r.schar = io[io_slot(DEF_SERIAL_DATA_ADDR)];
                            io[io_slot(a)] = acc.wdata & SERIAL_MASK;
                        end else if (a == DEF_DIVIDER_ADDR) begin
                            io[io_slot(a)] = 8'h00;
                        end
                    end
                    else begin
                        hram[a - ADDR_HRAM]     = acc.wdata;
                        hram_set[a - ADDR_HRAM] = 1'b1;
                    end
                end
                OP_LOAD: begin
                    boot[a[7:0]]     = acc.wdata;
                    boot_set[a[7:0]] = 1'b1;
                end
                default: begin
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_bus_result got);
            t_bus_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with no access pending: expected none, actual %p",
                         $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("read_data", want.rdata, got.rdata);
            check_field("cart_select", {7'd0, want.csel}, {7'd0, got.csel});
            check_field("cart_write_strobe", {7'd0, want.cwr}, {7'd0, got.cwr});
            check_field("serial_valid", {7'd0, want.sval}, {7'd0, got.sval});
            check_field("serial_char", want.schar, got.schar);
        endfunction
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [1:0]  i_cfg_index      = '0;
    logic [2:0]  i_cfg_data       = '0;
    logic        i_in_valid       = 1'b0;
    logic [1:0]  i_func           = '0;
    logic [15:0] i_address        = '0;
    logic [7:0]  i_write_data     = '0;
    logic [7:0]  i_cart_read_data = '0;
    logic        i_out_ready      = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_read_data;
    logic        o_cart_select;
    logic        o_cart_write_strobe;
    logic        o_serial_valid;
    logic [7:0]  o_serial_char;

    t_bus_scoreboard sb;
    t_bus_access     seen_access;
    logic [15:0]     touched_addrs [$];
    int              tx_idle_pct = 0;
    int              rx_idle_pct = 0;

    console_memory_bus_decoder u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_address           (i_address),
        .i_write_data        (i_write_data),
        .i_cart_read_data    (i_cart_read_data),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_read_data         (o_read_data),
        .o_cart_select       (o_cart_select),
        .o_cart_write_strobe (o_cart_write_strobe),
        .o_serial_valid      (o_serial_valid),
        .o_serial_char       (o_serial_char)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Results are checked before the accepted access is noted, so a beat
    // accepted on this edge never answers itself.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result({o_read_data, o_cart_select, o_cart_write_strobe,
                                 o_serial_valid, o_serial_char});
            end
            if (i_in_valid && o_in_ready) begin
                seen_access.op    = t_op'(i_func);
                seen_access.addr  = i_address;
                seen_access.wdata = i_write_data;
                seen_access.cdata = i_cart_read_data;
                sb.note_access(seen_access);
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("console_memory_bus_decoder verification failed");
        $finish;
    end

    // Called and returning at a falling edge.
    task automatic send_access(t_bus_access acc);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= acc.op;
        i_address        <= acc.addr;
        i_write_data     <= acc.wdata;
        i_cart_read_data <= acc.cdata;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic bus_op(t_op op, logic [15:0] a, logic [7:0] wd);
        t_bus_access acc;
        acc.op    = op;
        acc.addr  = a;
        acc.wdata = wd;
        acc.cdata = 8'($urandom_range(0, 255));
        send_access(acc);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(logic vb, logic [2:0] wb, logic cp);
        logic [1:0] idx [3];
        logic [2:0] vals [3];
        idx[0]  = CFG_VIDEO_BANK;
        idx[1]  = CFG_WORK_BANK;
        idx[2]  = CFG_CART_PRESENT;
        vals[0] = {2'b00, vb};
        vals[1] = wb;
        vals[2] = {2'b00, cp};
        for (int k = 0; k < 3; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.write_register(idx[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] random_address();
        logic [15:0] a;
        case ($urandom_range(0, 11))
            0:  a = 16'($urandom_range(0, 16'h7FFF));
            1:  a = 16'($urandom_range(0, ADDR_BOOT_END - 1));
            2:  a = 16'($urandom_range(ADDR_VRAM, ADDR_XRAM - 1));
            3:  a = 16'($urandom_range(ADDR_XRAM, ADDR_WRAM0 - 1));
            4:  a = 16'($urandom_range(ADDR_WRAM0, ADDR_WRAMX - 1));
            5:  a = 16'($urandom_range(ADDR_WRAMX, ADDR_ECHO - 1));
            6:  a = 16'($urandom_range(ADDR_ECHO, ADDR_OAM - 1));
            7:  a = 16'($urandom_range(ADDR_OAM, ADDR_RSVD - 1));
            8:  a = 16'($urandom_range(ADDR_RSVD, ADDR_IO - 1));
            9: begin
                a = 16'($urandom_range(ADDR_IO, ADDR_HRAM - 1));
                case ($urandom_range(0, 5))
                    0: a = DEF_SERIAL_DATA_ADDR;
                    1: a = DEF_SERIAL_CTRL_ADDR;
                    2: a = DEF_DIVIDER_ADDR;
                    3: a = DEF_BOOT_OFF_ADDR;
                    default: begin
                    end
                endcase
            end
            10: a = 16'($urandom_range(ADDR_HRAM, ADDR_IE - 1));
            default: a = ADDR_IE;
        endcase
        return a;
    endfunction

    // Reads favor recently written addresses; a read that would hit an
    // unwritten entry becomes a write to it instead.
    function automatic t_bus_access random_access();
        t_bus_access acc;
        int pick;
        acc.wdata = 8'($urandom_range(0, 255));
        acc.cdata = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 45) acc.op = OP_READ;
        else if (pick < 85) acc.op = OP_WRITE;
        else if (pick < 95) acc.op = OP_LOAD;
        else acc.op = OP_NONE;
        if (acc.op == OP_READ && touched_addrs.size() != 0 && $urandom_range(0, 1) == 1)
            acc.addr = touched_addrs[$urandom_range(0, touched_addrs.size() - 1)];
        else
            acc.addr = random_address();
        if (acc.op == OP_READ && !sb.read_defined(acc.addr)) acc.op = OP_WRITE;
        if (acc.op == OP_WRITE && $urandom_range(0, 1) == 1) begin
            if (acc.addr == DEF_BOOT_OFF_ADDR) acc.wdata = 8'h00;
            else if (acc.addr == DEF_SERIAL_CTRL_ADDR) acc.wdata = SERIAL_GO;
        end
        return acc;
    endfunction

    initial begin
        t_bus_access acc;
        int sent;
        sb = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 18;
        rx_idle_pct = 57;

        // Boot ROM window, open bus and every store at its edges.
        bus_op(OP_LOAD, 16'h0000, 8'h3C);
        bus_op(OP_LOAD, 16'hFFFF, 8'hC3);
        bus_op(OP_READ, 16'h0000, 8'h00);
        bus_op(OP_READ, 16'h00FF, 8'hFF);
        bus_op(OP_READ, ADDR_BOOT_END, 8'h00);
        bus_op(OP_WRITE, 16'h7FFF, 8'hFF);
        bus_op(OP_WRITE, ADDR_IE, 8'hA5);
        bus_op(OP_READ, ADDR_IE, 8'h00);
        bus_op(OP_WRITE, ADDR_WRAM0 - 1, 8'h00);
        bus_op(OP_WRITE, ADDR_XRAM - 1, 8'h6E);
        bus_op(OP_READ, ADDR_XRAM - 1, 8'h00);
        bus_op(OP_WRITE, ADDR_ECHO - 1, 8'h22);
        bus_op(OP_READ, ADDR_ECHO - 1, 8'h00);
        bus_op(OP_WRITE, ADDR_ECHO, 8'h77);
        bus_op(OP_READ, ADDR_OAM - 1, 8'h00);
        bus_op(OP_WRITE, ADDR_RSVD - 1, 8'h5A);
        bus_op(OP_READ, ADDR_RSVD - 1, 8'h00);
        bus_op(OP_READ, ADDR_RSVD, 8'h00);
        bus_op(OP_WRITE, DEF_SERIAL_DATA_ADDR, 8'h96);
        bus_op(OP_WRITE, DEF_SERIAL_CTRL_ADDR, SERIAL_GO);
        bus_op(OP_READ, DEF_SERIAL_CTRL_ADDR, 8'h00);
        bus_op(OP_WRITE, DEF_DIVIDER_ADDR, 8'h55);
        bus_op(OP_READ, DEF_DIVIDER_ADDR, 8'h00);
        bus_op(OP_WRITE, ADDR_IE - 1, 8'h34);
        bus_op(OP_READ, ADDR_IE - 1, 8'h00);
        bus_op(OP_NONE, ADDR_IE, 8'hFF);
        bus_op(OP_WRITE, DEF_BOOT_OFF_ADDR, 8'h01);
        bus_op(OP_READ, 16'h0000, 8'h00);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            tx_idle_pct = (phase < 2) ? 18 : (phase < 4) ? 57 : 0;
            rx_idle_pct = (phase < 2) ? 57 : (phase < 4) ? 18 : 0;
            case (phase)
                0: set_config(1'b1, 3'd7, 1'b1);
                1: set_config(1'b0, 3'd0, 1'b0);
                2: set_config(1'b1, 3'd2, 1'b1);
                3: set_config(1'b0, 3'd5, 1'b0);
                4: set_config(1'b0, 3'd7, 1'b1);
                default: set_config(1'b1, 3'd3, 1'b1);
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 24) == 0) begin
                    // Load the serial data byte, then start a transfer.
                    bus_op(OP_WRITE, DEF_SERIAL_DATA_ADDR, 8'($urandom_range(0, 255)));
                    bus_op(OP_WRITE, DEF_SERIAL_CTRL_ADDR, SERIAL_GO);
                    sent += 2;
                end else begin
                    acc = random_access();
                    if (acc.op == OP_WRITE) touched_addrs.push_back(acc.addr);
                    else if (acc.op == OP_LOAD) touched_addrs.push_back({8'h00, acc.addr[7:0]});
                    if (touched_addrs.size() > 48) void'(touched_addrs.pop_front());
                    send_access(acc);
                    sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("console_memory_bus_decoder verification clean");
        end else begin
            $display("console_memory_bus_decoder verification failed");
        end
        $finish;
    end

endmodule

// File: console_memory_bus_decoder.f
sv/cmbd_pkg.sv
sv/cmbd_ram.sv
sv/cmbd_decode.sv
sv/console_memory_bus_decoder.sv
bench/console_memory_bus_decoder_tb.sv
